// ===== rtl/ffa_pkg.sv =====
// shared types, codes and defaults of the first-fit region allocator
`default_nettype none
package ffa_pkg;

    // fixed field widths of the request and response beats
    localparam int REQ_W    = 3;
    localparam int LEN_W    = 11;
    localparam int SEL_W    = 4;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 11;

    // parameter defaults
    localparam int REGION_BYTES_DEF = 1024;
    localparam int NUM_SLOTS_DEF    = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TRIM_FR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TRIM_BK = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd3;

    // shared adder operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // flags from the shared adder
    typedef struct packed {
        logic borrow;
        logic zero;
    } alu_flags_t;

endpackage
`default_nettype wire

// ===== rtl/first_fit_region_allocator.sv =====
// first-fit region allocator: request decode, slot sequencer and response register
// one request at a time, held from the accepting edge to the response beat,
//   and the next request is taken in the cycle after that beat loads (a stalled beat holds it)
// allocate: slot visits over at most NUM_SLOTS+1 passes, then a scan of the slots to
//   pick the lowest free one; find owner: one scan over the slots
// trim and release: read, then update; unused slot, clear all, unknown codes: go to post
// async reset clears all used flags and the sequencer; slot ram contents are not cleared
`default_nettype none
module first_fit_region_allocator #(
    parameter int REGION_BYTES = ffa_pkg::REGION_BYTES_DEF,
    parameter int NUM_SLOTS    = ffa_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [ffa_pkg::REQ_W-1:0]      req_type,
    input  wire logic [ffa_pkg::LEN_W-1:0]      length,
    input  wire logic [ffa_pkg::SEL_W-1:0]      slot_sel,
    input  wire logic [ffa_pkg::ADDR_W-1:0]     byte_addr,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic [ffa_pkg::STATUS_W-1:0]        status,
    output logic [ffa_pkg::SEL_W-1:0]           slot_out,
    output logic [ffa_pkg::OUT_W-1:0]           start_out,
    output logic [ffa_pkg::OUT_W-1:0]           size_out
);

    localparam int OFS_W   = $clog2(REGION_BYTES + 1);
    localparam int LEN_W   = ffa_pkg::LEN_W;
    localparam int CMP_W   = ((OFS_W > LEN_W) ? OFS_W : LEN_W) + 1;
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SEL_W   = ffa_pkg::SEL_W;
    localparam int OUT_W   = ffa_pkg::OUT_W;
    localparam int ST_W    = ffa_pkg::STATUS_W;
    localparam int ENTRY_W = 2 * OFS_W;

    localparam logic [CMP_W-1:0] REGION = CMP_W'(REGION_BYTES);
    localparam logic [CNT_W-1:0] SLOTS  = CNT_W'(NUM_SLOTS);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_A_TOP  = 5'd2;
    localparam logic [4:0] S_A_GAP  = 5'd3;
    localparam logic [4:0] S_A_CMP  = 5'd4;
    localparam logic [4:0] S_A_FIT  = 5'd5;
    localparam logic [4:0] S_A_END  = 5'd6;
    localparam logic [4:0] S_A_ROOM = 5'd7;
    localparam logic [4:0] S_A_FREE = 5'd8;
    localparam logic [4:0] S_T_SUB  = 5'd9;
    localparam logic [4:0] S_T_ADD  = 5'd10;
    localparam logic [4:0] S_R_OUT  = 5'd11;
    localparam logic [4:0] S_F_TOP  = 5'd12;
    localparam logic [4:0] S_F_SUB  = 5'd13;
    localparam logic [4:0] S_F_CMP  = 5'd14;
    localparam logic [4:0] S_POST   = 5'd15;

    logic [4:0]                 state_reg, state_next;
    logic [NUM_SLOTS-1:0]       used_reg, used_next;
    logic [CMP_W-1:0]           start_reg, start_next;
    logic [CMP_W-1:0]           room_reg, room_next;
    logic [CMP_W-1:0]           gap_reg, gap_next;
    logic [CNT_W-1:0]           j_reg, j_next;

    logic [ffa_pkg::REQ_W-1:0]  req_type_reg;
    logic [LEN_W-1:0]           length_reg;
    logic [SEL_W-1:0]           slot_sel_reg;
    logic [ffa_pkg::ADDR_W-1:0] byte_addr_reg;

    logic [ST_W-1:0]            res_status_reg, res_status_next;
    logic [SEL_W-1:0]           res_slot_reg, res_slot_next;
    logic [OUT_W-1:0]           res_start_reg, res_start_next;
    logic [OUT_W-1:0]           res_size_reg, res_size_next;

    logic                       rsp_valid_reg;
    logic [ST_W-1:0]            status_reg;
    logic [SEL_W-1:0]           slot_out_reg;
    logic [OUT_W-1:0]           start_out_reg;
    logic [OUT_W-1:0]           size_out_reg;

    logic                       req_fire;
    logic                       rsp_free;
    logic                       rsp_load;
    logic [SLOT_AW-1:0]         j_idx;
    logic [SLOT_AW-1:0]         sel_idx;
    logic                       sel_ok;
    logic                       j_in_range;
    logic [CMP_W-1:0]           size_x;

    logic                       ram_we;
    logic                       ram_re;
    logic [SLOT_AW-1:0]         ram_waddr;
    logic [SLOT_AW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic [CMP_W-1:0]           rd_s;
    logic [CMP_W-1:0]           rd_l;

    logic                       alu_op;
    logic [CMP_W-1:0]           alu_a;
    logic [CMP_W-1:0]           alu_b;
    logic [CMP_W-1:0]           alu_res;
    ffa_pkg::alu_flags_t        alu_flags;

    // handshake
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = (state_reg == S_POST) && rsp_free;

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign start_out = start_out_reg;
    assign size_out  = size_out_reg;

    // slot indexes and decoded request fields
    assign j_idx      = SLOT_AW'(j_reg);
    assign sel_idx    = SLOT_AW'(slot_sel_reg);
    assign j_in_range = (j_reg < SLOTS);
    assign sel_ok     = (32'(slot_sel_reg) < NUM_SLOTS) && used_reg[sel_idx];
    assign size_x     = CMP_W'(length_reg);
    assign rd_s       = CMP_W'(ram_rdata[ENTRY_W-1:OFS_W]);
    assign rd_l       = CMP_W'(ram_rdata[OFS_W-1:0]);

    // slot start/length store
    ffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared adder
    ffa_alu #(
        .W (CMP_W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    // adder operand select per step
    always_comb
    begin
        alu_op = ffa_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_A_TOP:
            begin
                alu_a = room_reg;
                alu_b = size_x;
            end
            S_A_GAP:
            begin
                alu_a = rd_s;
                alu_b = start_reg;
            end
            S_A_CMP:
            begin
                alu_a = gap_reg;
                alu_b = room_reg;
            end
            S_A_FIT:
            begin
                alu_a = room_reg;
                alu_b = size_x;
            end
            S_A_END:
            begin
                alu_op = ffa_pkg::ALU_ADD;
                alu_a  = rd_s;
                alu_b  = rd_l;
            end
            S_A_ROOM:
            begin
                alu_a = REGION;
                alu_b = start_reg;
            end
            S_T_SUB:
            begin
                alu_a = rd_l;
                alu_b = size_x;
            end
            S_T_ADD:
            begin
                alu_op = ffa_pkg::ALU_ADD;
                alu_a  = rd_s;
                alu_b  = size_x;
            end
            S_F_SUB:
            begin
                alu_a = CMP_W'(byte_addr_reg);
                alu_b = rd_s;
            end
            S_F_CMP:
            begin
                alu_a = gap_reg;
                alu_b = rd_l;
            end
            default:
            begin
                alu_op = ffa_pkg::ALU_SUB;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        start_next      = start_reg;
        room_next       = room_reg;
        gap_next        = gap_reg;
        j_next          = j_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_start_next  = res_start_reg;
        res_size_next   = res_size_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = j_idx;
        ram_raddr       = j_idx;
        ram_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_DECODE;
                end
            end

            // route the request, default response is all zero
            S_DECODE:
            begin
                res_status_next = ffa_pkg::ST_OK;
                res_slot_next   = '0;
                res_start_next  = '0;
                res_size_next   = '0;
                j_next          = '0;
                priority case (1'b1)
                    (req_type_reg == ffa_pkg::REQ_ALLOC):
                    begin
                        start_next = '0;
                        room_next  = REGION;
                        state_next = S_A_TOP;
                    end
                    (req_type_reg == ffa_pkg::REQ_TRIM_FR) ||
                    (req_type_reg == ffa_pkg::REQ_TRIM_BK) ||
                    (req_type_reg == ffa_pkg::REQ_RELEASE):
                    begin
                        res_slot_next = slot_sel_reg;
                        if (!sel_ok)
                        begin
                            res_status_next = ffa_pkg::ST_NO_OWNER;
                            state_next      = S_POST;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = sel_idx;
                            state_next = (req_type_reg == ffa_pkg::REQ_RELEASE) ?
                                         S_R_OUT : S_T_SUB;
                        end
                    end
                    (req_type_reg == ffa_pkg::REQ_FIND):
                    begin
                        state_next = S_F_TOP;
                    end
                    (req_type_reg == ffa_pkg::REQ_CLEAR):
                    begin
                        used_next  = '0;
                        state_next = S_POST;
                    end
                    default:
                    begin
                        state_next = S_POST;
                    end
                endcase
            end

            // loop head: continue while slots remain and the gap still fits
            S_A_TOP:
            begin
                if (alu_flags.borrow)
                begin
                    res_status_next = ffa_pkg::ST_NO_MEM;
                    state_next      = S_POST;
                end
                else if (j_in_range)
                begin
                    ram_re     = 1'b1;
                    state_next = S_A_GAP;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_A_FREE;
                end
            end

            // used, non-empty slot at or after the candidate start
            S_A_GAP:
            begin
                if (used_reg[j_idx] && (rd_l != '0) && !alu_flags.borrow)
                begin
                    gap_next   = alu_res;
                    state_next = S_A_CMP;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_A_TOP;
                end
            end

            // nearer bound shrinks the room
            S_A_CMP:
            begin
                if (alu_flags.borrow)
                begin
                    room_next  = gap_reg;
                    state_next = S_A_FIT;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_A_TOP;
                end
            end

            // gap too small: restart past this slot
            S_A_FIT:
            begin
                if (alu_flags.borrow)
                begin
                    state_next = S_A_END;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_A_TOP;
                end
            end

            S_A_END:
            begin
                start_next = alu_res;
                state_next = S_A_ROOM;
            end

            // room past the end saturates to zero
            S_A_ROOM:
            begin
                room_next  = alu_flags.borrow ? '0 : alu_res;
                j_next     = '0;
                state_next = S_A_TOP;
            end

            // lowest unused slot takes the region
            S_A_FREE:
            begin
                if (!j_in_range)
                begin
                    res_status_next = ffa_pkg::ST_NO_SLOT;
                    state_next      = S_POST;
                end
                else if (!used_reg[j_idx])
                begin
                    used_next[j_idx] = 1'b1;
                    ram_we           = 1'b1;
                    ram_wdata        = {start_reg[OFS_W-1:0], size_x[OFS_W-1:0]};
                    res_slot_next    = SEL_W'(j_idx);
                    res_start_next   = OUT_W'(start_reg);
                    res_size_next    = OUT_W'(size_x);
                    state_next       = S_POST;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end

            // trim: length minus amount, zero when the amount covers it
            S_T_SUB:
            begin
                ram_waddr = sel_idx;
                if (alu_flags.borrow || alu_flags.zero)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = {rd_s[OFS_W-1:0], {OFS_W{1'b0}}};
                    res_start_next = OUT_W'(rd_s);
                    res_size_next  = '0;
                    state_next     = S_POST;
                end
                else if (req_type_reg == ffa_pkg::REQ_TRIM_BK)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = {rd_s[OFS_W-1:0], alu_res[OFS_W-1:0]};
                    res_start_next = OUT_W'(rd_s);
                    res_size_next  = OUT_W'(alu_res);
                    state_next     = S_POST;
                end
                else
                begin
                    gap_next   = alu_res;
                    state_next = S_T_ADD;
                end
            end

            // trim front moves the start
            S_T_ADD:
            begin
                ram_we         = 1'b1;
                ram_waddr      = sel_idx;
                ram_wdata      = {alu_res[OFS_W-1:0], gap_reg[OFS_W-1:0]};
                res_start_next = OUT_W'(alu_res);
                res_size_next  = OUT_W'(gap_reg);
                state_next     = S_POST;
            end

            S_R_OUT:
            begin
                used_next[sel_idx] = 1'b0;
                res_start_next     = OUT_W'(rd_s);
                res_size_next      = OUT_W'(rd_l);
                state_next         = S_POST;
            end

            // find owner scan
            S_F_TOP:
            begin
                if (j_in_range)
                begin
                    ram_re     = 1'b1;
                    state_next = S_F_SUB;
                end
                else
                begin
                    res_status_next = ffa_pkg::ST_NO_OWNER;
                    state_next      = S_POST;
                end
            end

            S_F_SUB:
            begin
                if (used_reg[j_idx] && !alu_flags.borrow)
                begin
                    gap_next   = alu_res;
                    state_next = S_F_CMP;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_F_TOP;
                end
            end

            // offset into the slot below its length
            S_F_CMP:
            begin
                if (alu_flags.borrow)
                begin
                    res_slot_next  = SEL_W'(j_idx);
                    res_start_next = OUT_W'(rd_s);
                    res_size_next  = OUT_W'(rd_l);
                    state_next     = S_POST;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_F_TOP;
                end
            end

            S_POST:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            room_reg      <= REGION;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            room_reg  <= room_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        gap_reg        <= gap_next;
        j_reg          <= j_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_start_reg  <= res_start_next;
        res_size_reg   <= res_size_next;
        if (req_fire)
        begin
            req_type_reg  <= req_type;
            length_reg    <= length;
            slot_sel_reg  <= slot_sel;
            byte_addr_reg <= byte_addr;
        end
        if (rsp_load)
        begin
            status_reg    <= res_status_reg;
            slot_out_reg  <= res_slot_reg;
            start_out_reg <= res_start_reg;
            size_out_reg  <= res_size_reg;
        end
    end

    // clear all empties the table
    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && req_type_reg == ffa_pkg::REQ_CLEAR) |=> (used_reg == '0))
        else $error("clear all left a slot in use");

    // a grant marks its slot used
    a_grant_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_FREE && j_in_range && !used_reg[j_idx])
        |=> used_reg[$past(j_idx)])
        else $error("granted slot not marked used");

    // room never exceeds the region
    a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_TOP) |-> !(room_reg > REGION))
        else $error("allocation room beyond region");

    // a response appears only from the post step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_POST))
        else $error("response raised outside post step");

endmodule
`default_nettype wire

// ===== rtl/ffa_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16
) (
    input  wire logic                                           clk,
    input  wire logic                                           we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                               wdata,
    input  wire logic                                           re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic      [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ffa_alu.sv =====
// shared add/subtract unit with borrow and zero flags
`default_nettype none
module ffa_alu #(
    parameter int W = 12
) (
    input  wire logic               op,
    input  wire logic [W-1:0]       a,
    input  wire logic [W-1:0]       b,
    output logic      [W-1:0]       res,
    output ffa_pkg::alu_flags_t     flags
);

    logic [W:0] sum;

    // one extra bit catches the borrow of a subtract
    always_comb
    begin
        if (op == ffa_pkg::ALU_SUB)
        begin
            sum = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            sum = {1'b0, a} + {1'b0, b};
        end
        res          = sum[W-1:0];
        flags.borrow = (op == ffa_pkg::ALU_SUB) && sum[W];
        flags.zero   = (sum[W-1:0] == '0);
    end

endmodule
`default_nettype wire
